// ===== hw/rtl/tccs_pkg.sv =====
// Package for the text console cursor/scroll core: geometry, codes, types
// and the ring-address helper. No dependencies.
package tccs_pkg;

    // Screen geometry and tab width
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_SPACES = 4;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    // Field widths on the stream ports
    localparam int REQ_TYPE_W      = 2;
    localparam int CHAR_CODE_W     = 8;
    localparam int COLOR_W         = 8;
    localparam int CELL_COLUMN_W   = 7;
    localparam int CELL_ROW_W      = 5;
    localparam int CURSOR_COLUMN_W = 7;
    localparam int CURSOR_ROW_W    = 5;
    localparam int CELL_DATA_W     = 16;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 32;

    // Character codes
    localparam logic [CHAR_CODE_W-1:0] CH_NULL    = 8'h00;
    localparam logic [CHAR_CODE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_CODE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_CODE_W-1:0] CH_SPACE   = 8'h20;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_RSVD  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_PUT,
        KIND_CLEAR,
        KIND_READ
    } kind_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT_ADDR,
        S_PUT_WRITE,
        S_SCROLL,
        S_CLEAR,
        S_READ_ADDR,
        S_READ_MEM,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic sweep_start;
        logic sweep_write;
        logic put_addr;
        logic put_write;
        logic scroll_write;
        logic read_addr;
        logic read_mem;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  put_scroll;
        logic  tab_left;
        logic  sweep_last;
        logic  scroll_last;
    } stat_t;

    // Physical cell address of a logical row/column under the ring offset
    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= (ROW_W+1)'(ROWS))
            sum = sum - (ROW_W+1)'(ROWS);
        return ADDR_W'(ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
    endfunction

endpackage

// ===== hw/rtl/tccs_ctrl.sv =====
// Controller FSM for the text console core: sequences init sweep, puts,
// scroll fills, clears and reads. Depends on tccs_pkg.
module tccs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  tccs_pkg::stat_t  stat,
    output tccs_pkg::cmd_t   cmd
);

    tccs_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tccs_pkg::S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccs_pkg::S_INIT:
                if (stat.sweep_last)
                    state_next = tccs_pkg::S_IDLE;
            tccs_pkg::S_IDLE:
                if (s_axis_tvalid)
                begin
                    unique case (stat.kind)
                        tccs_pkg::KIND_PUT:   state_next = tccs_pkg::S_PUT_ADDR;
                        tccs_pkg::KIND_CLEAR: state_next = tccs_pkg::S_CLEAR;
                        tccs_pkg::KIND_READ:  state_next = tccs_pkg::S_READ_ADDR;
                        tccs_pkg::KIND_NOP:   state_next = tccs_pkg::S_DONE;
                    endcase
                end
            tccs_pkg::S_PUT_ADDR:
                state_next = tccs_pkg::S_PUT_WRITE;
            tccs_pkg::S_PUT_WRITE:
                priority if (stat.put_scroll)
                    state_next = tccs_pkg::S_SCROLL;
                else if (stat.tab_left)
                    state_next = tccs_pkg::S_PUT_ADDR;
                else
                    state_next = tccs_pkg::S_DONE;
            tccs_pkg::S_SCROLL:
                if (stat.scroll_last)
                    state_next = stat.tab_left ? tccs_pkg::S_PUT_ADDR : tccs_pkg::S_DONE;
            tccs_pkg::S_CLEAR:
                if (stat.sweep_last)
                    state_next = tccs_pkg::S_DONE;
            tccs_pkg::S_READ_ADDR:
                state_next = tccs_pkg::S_READ_MEM;
            tccs_pkg::S_READ_MEM:
                state_next = tccs_pkg::S_DONE;
            tccs_pkg::S_DONE:
                if (!out_valid_reg || m_axis_tready)
                    state_next = tccs_pkg::S_IDLE;
            default:
                state_next = tccs_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd              = '0;
        s_axis_tready    = (state_reg == tccs_pkg::S_IDLE);
        cmd.accept       = s_axis_tready && s_axis_tvalid;
        cmd.sweep_start  = cmd.accept && (stat.kind == tccs_pkg::KIND_CLEAR);
        cmd.sweep_write  = (state_reg == tccs_pkg::S_INIT) || (state_reg == tccs_pkg::S_CLEAR);
        cmd.put_addr     = (state_reg == tccs_pkg::S_PUT_ADDR);
        cmd.put_write    = (state_reg == tccs_pkg::S_PUT_WRITE);
        cmd.scroll_write = (state_reg == tccs_pkg::S_SCROLL);
        cmd.read_addr    = (state_reg == tccs_pkg::S_READ_ADDR);
        cmd.read_mem     = (state_reg == tccs_pkg::S_READ_MEM);
        cmd.load_out     = (state_reg == tccs_pkg::S_DONE) && (!out_valid_reg || m_axis_tready);
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_axis_tvalid = out_valid_reg;

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != tccs_pkg::S_INIT |=> state_reg != tccs_pkg::S_INIT)
        else $error("init sweep re-entered");

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tccs_pkg::S_DONE))
        else $error("result raised outside done state");

endmodule

// ===== hw/rtl/tccs_datapath.sv =====
// Datapath for the text console core: screen memory, cursor, ring offset,
// address counters and the result register. Depends on tccs_pkg.
module tccs_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [tccs_pkg::REQ_TYPE_W-1:0]        req_type,
    input  logic [tccs_pkg::CHAR_CODE_W-1:0]       char_code,
    input  logic [tccs_pkg::COLOR_W-1:0]           color,
    input  logic [tccs_pkg::CELL_COLUMN_W-1:0]     cell_column,
    input  logic [tccs_pkg::CELL_ROW_W-1:0]        cell_row,
    input  tccs_pkg::cmd_t                         cmd,
    output tccs_pkg::stat_t                        stat,
    output logic [tccs_pkg::CURSOR_COLUMN_W-1:0]   cursor_column,
    output logic [tccs_pkg::CURSOR_ROW_W-1:0]      cursor_row,
    output logic [tccs_pkg::CELL_DATA_W-1:0]       cell_data,
    output logic                                   did_scroll
);

    logic [tccs_pkg::CELL_DATA_W-1:0] mem [tccs_pkg::CELLS];

    logic [tccs_pkg::CHAR_CODE_W-1:0] ch_reg;
    logic [tccs_pkg::COLOR_W-1:0]     color_reg;
    logic [tccs_pkg::COL_W-1:0]       rc_reg;
    logic [tccs_pkg::ROW_W-1:0]       rr_reg;
    logic                             read_ok_reg;
    logic [tccs_pkg::TAB_W-1:0]       tab_cnt_reg;
    logic                             scrolled_reg;
    logic [tccs_pkg::COL_W-1:0]       cur_col_reg;
    logic [tccs_pkg::ROW_W-1:0]       cur_row_reg;
    logic [tccs_pkg::ROW_W-1:0]       top_reg;
    logic [tccs_pkg::ADDR_W-1:0]      addr_reg;
    logic [tccs_pkg::COL_W-1:0]       scol_reg;
    logic [tccs_pkg::CELL_DATA_W-1:0] rdata_reg;

    logic [tccs_pkg::CURSOR_COLUMN_W-1:0] out_col_reg;
    logic [tccs_pkg::CURSOR_ROW_W-1:0]    out_row_reg;
    logic [tccs_pkg::CELL_DATA_W-1:0]     out_data_reg;
    logic                                 out_scroll_reg;

    logic [tccs_pkg::CHAR_CODE_W-1:0] eff_ch;
    logic                             is_nl;
    logic [tccs_pkg::COL_W:0]         col_inc;
    logic [tccs_pkg::ROW_W:0]         row_inc;
    logic                             row_adv;
    logic                             row_wrap;
    logic [tccs_pkg::COL_W-1:0]       put_col_next;
    logic [tccs_pkg::ROW_W-1:0]       put_row_next;
    logic [tccs_pkg::ROW_W-1:0]       top_inc;
    logic                             rd_in_range;
    logic                             mem_we;
    logic [tccs_pkg::CELL_DATA_W-1:0] mem_wdata;

    // Request decode straight from the input fields, plus status to the controller
    always_comb
    begin
        unique case (tccs_pkg::req_t'(req_type))
            tccs_pkg::REQ_PUT:
                stat.kind = (char_code == tccs_pkg::CH_NULL) ? tccs_pkg::KIND_NOP
                                                             : tccs_pkg::KIND_PUT;
            tccs_pkg::REQ_CLEAR: stat.kind = tccs_pkg::KIND_CLEAR;
            tccs_pkg::REQ_READ:  stat.kind = tccs_pkg::KIND_READ;
            default:             stat.kind = tccs_pkg::KIND_NOP;
        endcase
        stat.put_scroll  = row_wrap;
        stat.tab_left    = (tab_cnt_reg != '0);
        stat.sweep_last  = (addr_reg == tccs_pkg::ADDR_W'(tccs_pkg::CELLS - 1));
        stat.scroll_last = (scol_reg == tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1));
    end

    assign rd_in_range = (cell_column < tccs_pkg::CELL_COLUMN_W'(tccs_pkg::COLUMNS))
                      && (cell_row < tccs_pkg::CELL_ROW_W'(tccs_pkg::ROWS));

    // One put step: tab expands to spaces, newline only moves the cursor
    always_comb
    begin
        eff_ch   = (ch_reg == tccs_pkg::CH_TAB) ? tccs_pkg::CH_SPACE : ch_reg;
        is_nl    = (eff_ch == tccs_pkg::CH_NEWLINE);
        col_inc  = (tccs_pkg::COL_W+1)'(cur_col_reg) + (tccs_pkg::COL_W+1)'(1);
        row_inc  = (tccs_pkg::ROW_W+1)'(cur_row_reg) + (tccs_pkg::ROW_W+1)'(1);
        row_adv  = is_nl || (col_inc == (tccs_pkg::COL_W+1)'(tccs_pkg::COLUMNS));
        row_wrap = row_adv && (row_inc == (tccs_pkg::ROW_W+1)'(tccs_pkg::ROWS));
        put_col_next = row_adv ? '0 : tccs_pkg::COL_W'(col_inc);
        if (row_wrap)
            put_row_next = tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1);
        else if (row_adv)
            put_row_next = tccs_pkg::ROW_W'(row_inc);
        else
            put_row_next = cur_row_reg;
        top_inc = (top_reg == tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1))
                ? '0 : top_reg + tccs_pkg::ROW_W'(1);
    end

    // Latched request and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg    <= '0;
            tab_cnt_reg  <= '0;
            scrolled_reg <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            top_reg      <= '0;
            addr_reg     <= '0;
            scol_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                color_reg    <= color;
                tab_cnt_reg  <= (char_code == tccs_pkg::CH_TAB)
                              ? tccs_pkg::TAB_W'(tccs_pkg::TAB_SPACES) : tccs_pkg::TAB_W'(1);
                scrolled_reg <= 1'b0;
            end
            if (cmd.sweep_start)
            begin
                cur_col_reg <= '0;
                cur_row_reg <= '0;
                top_reg     <= '0;
                addr_reg    <= '0;
            end
            if (cmd.sweep_write || cmd.scroll_write)
                addr_reg <= addr_reg + tccs_pkg::ADDR_W'(1);
            if (cmd.scroll_write)
                scol_reg <= scol_reg + tccs_pkg::COL_W'(1);
            if (cmd.put_addr)
            begin
                addr_reg    <= tccs_pkg::phys_addr(top_reg, cur_row_reg, cur_col_reg);
                tab_cnt_reg <= tab_cnt_reg - tccs_pkg::TAB_W'(1);
            end
            if (cmd.put_write)
            begin
                cur_col_reg <= put_col_next;
                cur_row_reg <= put_row_next;
                if (row_wrap)
                begin
                    // Old top physical row becomes the new bottom row: fill it
                    addr_reg     <= tccs_pkg::ADDR_W'(tccs_pkg::ADDR_W'(top_reg)
                                  * tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS));
                    top_reg      <= top_inc;
                    scol_reg     <= '0;
                    scrolled_reg <= 1'b1;
                end
            end
            if (cmd.read_addr)
                addr_reg <= tccs_pkg::phys_addr(top_reg, rr_reg, rc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg      <= char_code;
            rc_reg      <= tccs_pkg::COL_W'(cell_column);
            rr_reg      <= tccs_pkg::ROW_W'(cell_row);
            read_ok_reg <= (stat.kind == tccs_pkg::KIND_READ) && rd_in_range;
        end
    end

    // Screen memory: one write port, one registered read port
    assign mem_we    = cmd.sweep_write || cmd.scroll_write || (cmd.put_write && !is_nl);
    assign mem_wdata = cmd.put_write ? {color_reg, eff_ch} : {color_reg, tccs_pkg::CH_SPACE};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_mem)
            rdata_reg <= mem[addr_reg];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_col_reg    <= tccs_pkg::CURSOR_COLUMN_W'(cur_col_reg);
            out_row_reg    <= tccs_pkg::CURSOR_ROW_W'(cur_row_reg);
            out_data_reg   <= read_ok_reg ? rdata_reg : '0;
            out_scroll_reg <= scrolled_reg;
        end
    end

    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cell_data     = out_data_reg;
    assign did_scroll    = out_scroll_reg;

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg < tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1) ||
        cur_col_reg == tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1))
        else $error("cursor column out of range");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg < tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1) ||
        top_reg == tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1))
        else $error("ring offset out of range");

    a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_write && row_wrap |=>
        cur_row_reg == tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1) && cur_col_reg == '0 && scrolled_reg)
        else $error("scroll did not park cursor on bottom row");

endmodule

// ===== hw/rtl/text_console_cursor_scroll_core.sv =====
// Top level of the text console cursor/scroll core: stream ports, field
// packing, controller and datapath. Depends on tccs_pkg, tccs_ctrl, tccs_datapath.
//
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | tuser: req_type; tdata: char_code, color, cell_column,
//            |           |        cell_row
//  m_axis    | out       | tdata: cursor_column, cursor_row, cell_data, did_scroll
//
// States per transaction (accept to result ready), one request at a time:
//   null char / unused type: done only; read: address, memory read, done; printable char or newline:
//   address, write, done; a scroll adds a fill of the new bottom row; a tab repeats the put step 4 times;
//   clear: a sweep of all ROWS*COLUMNS (2000) cells, then done. The single write port of the screen memory
//   sets the fill and clear times.
// After reset the core sweeps all ROWS*COLUMNS (2000) cells of the screen memory to blank cells,
//   with s_axis_tready low.
// A finished result waits in the output register; the core returns to idle
//   as soon as that register is free, so a stalled m_axis holds only the next result.
module text_console_cursor_scroll_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: char_code[7:0], color[15:8], cell_column[22:16], cell_row[27:23], zero[31:28]
    input  logic [tccs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [tccs_pkg::REQ_TYPE_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: cursor_column[6:0], cursor_row[11:7], cell_data[27:12], did_scroll[28],
    //        zero[31:29]
    output logic [tccs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    tccs_pkg::cmd_t  cmd;
    tccs_pkg::stat_t stat;

    logic [tccs_pkg::CURSOR_COLUMN_W-1:0] cursor_column;
    logic [tccs_pkg::CURSOR_ROW_W-1:0]    cursor_row;
    logic [tccs_pkg::CELL_DATA_W-1:0]     cell_data;
    logic                                 did_scroll;

    tccs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Unpack request fields from tdata
    tccs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (s_axis_tuser),
        .char_code     (s_axis_tdata[7:0]),
        .color         (s_axis_tdata[15:8]),
        .cell_column   (s_axis_tdata[22:16]),
        .cell_row      (s_axis_tdata[27:23]),
        .cmd           (cmd),
        .stat          (stat),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cell_data     (cell_data),
        .did_scroll    (did_scroll)
    );

    // Pack result fields, lowest first, zero-fill to a whole word
    assign m_axis_tdata = {3'b000, did_scroll, cell_data, cursor_row, cursor_column};

endmodule
